/* rtl/dgms_pkg.sv */
`default_nettype none

package dgms_pkg;

    localparam int COORD_W     = 16;
    localparam int INDEX_W     = 18;
    localparam int NORMAL_W    = 16;
    localparam int COUNT_W     = 21;
    localparam int KIND_W      = 2;
    localparam int REG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int STEP_W      = 8;
    localparam int GAP_W       = 15;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_READY  = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] COUNT_PER_TRI = COUNT_W'(3);

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_TRIANGLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NORMAL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY  = 2'd2;

    // Register indexes
    localparam logic [REG_INDEX_W-1:0] REG_STEP_SIZE       = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_FACE_NEGATIVE_Z = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_GAP_LIMIT       = 2'd2;

    // Register reset values
    localparam logic [STEP_W-1:0] STEP_SIZE_RESET = 8'd1;
    localparam logic              FACE_NEG_RESET  = 1'b1;
    localparam logic [GAP_W-1:0]  GAP_LIMIT_RESET = 15'd410;

    typedef struct packed {
        logic signed [COORD_W-1:0] tl_x;
        logic signed [COORD_W-1:0] tl_y;
        logic signed [COORD_W-1:0] tl_z;
        logic signed [COORD_W-1:0] tr_x;
        logic signed [COORD_W-1:0] tr_y;
        logic signed [COORD_W-1:0] tr_z;
        logic signed [COORD_W-1:0] bl_x;
        logic signed [COORD_W-1:0] bl_y;
        logic signed [COORD_W-1:0] bl_z;
        logic signed [COORD_W-1:0] br_x;
        logic signed [COORD_W-1:0] br_y;
        logic signed [COORD_W-1:0] br_z;
    } cell_t;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic [INDEX_W-1:0]         index_a;
        logic [INDEX_W-1:0]         index_b;
        logic [INDEX_W-1:0]         index_c;
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [NORMAL_W-1:0] normal_y;
        logic signed [NORMAL_W-1:0] normal_z;
        logic [COUNT_W-1:0]         index_count;
        logic                       mesh_ready;
        logic                       last;
    } result_t;

endpackage

`default_nettype wire

/* rtl/depth_grid_mesh_stitcher_core.sv */
// Timing: the input stays stalled until the cell's position update, and a frame summary
//   is loaded in that update. A cell with no kept triangle goes there from its tests. Each
//   kept triangle adds the work for its normal (cross product, normalize, 25-step square
//   root, three divides), the lower one also its shared corners, and a cell with both the
//   averaged normal. Output stalls add cycles. One cell at a time.
// Reset: asynchronous, active low; clears position, count, registers and output register.
`default_nettype none

module depth_grid_mesh_stitcher_core #(
    parameter int GRID_WIDTH  = 512,
    parameter int GRID_HEIGHT = 424
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cell_valid,
    output logic                                      cell_stall,
    input  wire dgms_pkg::cell_t                      grid_cell,
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output dgms_pkg::result_t                         result,
    input  wire logic                                 write_enable,
    input  wire logic [dgms_pkg::REG_INDEX_W-1:0]     reg_index,
    input  wire logic [dgms_pkg::CFG_DATA_W-1:0]      write_data
);

    localparam int COL_W  = $clog2(GRID_WIDTH);
    localparam int ROW_W  = $clog2(GRID_HEIGHT);
    localparam int POS_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W  = ((POS_W > 9) ? POS_W : 9) + 1;
    localparam int HALF_H = GRID_HEIGHT / 2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LIM, ST_BASE, ST_WSTEP, ST_TEST,
        ST_TRI_U, ST_TRI_L, ST_CROSS, ST_NINIT, ST_NORM, ST_SQ, ST_SQRT,
        ST_DIVINIT, ST_DIV, ST_EMIT_NTL, ST_EMIT_NBR, ST_EMIT_BL, ST_EMIT_TR,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {PH_TL, PH_BR, PH_AVG} phase_t;

    state_t                     state_reg;
    phase_t                     phase_reg;
    dgms_pkg::cell_t            cell_reg;
    dgms_pkg::result_t          result_reg;
    logic                       result_valid_reg;

    logic [7:0]                 step_size_reg;
    logic                       face_neg_reg;
    logic [14:0]                gap_limit_reg;
    logic [COL_W-1:0]           col_reg;
    logic [ROW_W-1:0]           row_reg;
    logic [20:0]                count_reg;

    logic [22:0]                lim_reg;
    logic [17:0]                base_reg;
    logic [17:0]                wstep_reg;
    logic [17:0]                i_tl_reg, i_tr_reg, i_bl_reg, i_br_reg;
    logic                       upper_reg, lower_reg, lastcol_reg, lastrow_reg;

    logic signed [16:0]         da_reg [3];
    logic signed [16:0]         db_reg [3];
    logic [2:0]                 step_cnt_reg;
    logic signed [34:0]         acc_reg;
    logic signed [34:0]         vec_reg [3];
    logic [2:0]                 neg_reg;
    logic [34:0]                mag_reg [3];
    logic [49:0]                sum_reg;
    logic [50:0]                s_reg;
    logic [50:0]                root_reg;
    logic [4:0]                 sq_cnt_reg;
    logic [1:0]                 comp_reg;
    logic [39:0]                num_reg;
    logic [3:0]                 div_cnt_reg;
    logic [14:0]                quo_reg;
    logic signed [15:0]         nres_reg [3];
    logic signed [15:0]         ntl_reg [3];

    // Effective stride
    logic [7:0] step_eff;
    logic [7:0] steps;
    always_comb
    begin
        step_eff = (step_size_reg == 8'd0) ? 8'd1 : step_size_reg;
        steps    = (int'(step_eff) > HALF_H) ? 8'(HALF_H) : step_eff;
    end

    // Shared multiplier
    logic signed [25:0] mul_a, mul_b;
    logic signed [51:0] mul_p;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LIM:
            begin
                mul_a = 26'(steps);
                mul_b = 26'(gap_limit_reg);
            end
            ST_BASE:
            begin
                mul_a = 26'(GRID_WIDTH);
                mul_b = 26'(row_reg);
            end
            ST_WSTEP:
            begin
                mul_a = 26'(GRID_WIDTH);
                mul_b = 26'(steps);
            end
            ST_CROSS:
            begin
                case (step_cnt_reg)
                    3'd0:
                    begin
                        mul_a = 26'(da_reg[1]);
                        mul_b = 26'(db_reg[2]);
                    end
                    3'd1:
                    begin
                        mul_a = 26'(da_reg[2]);
                        mul_b = 26'(db_reg[1]);
                    end
                    3'd2:
                    begin
                        mul_a = 26'(da_reg[2]);
                        mul_b = 26'(db_reg[0]);
                    end
                    3'd3:
                    begin
                        mul_a = 26'(da_reg[0]);
                        mul_b = 26'(db_reg[2]);
                    end
                    3'd4:
                    begin
                        mul_a = 26'(da_reg[0]);
                        mul_b = 26'(db_reg[1]);
                    end
                    3'd5:
                    begin
                        mul_a = 26'(da_reg[1]);
                        mul_b = 26'(db_reg[0]);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_SQ:
            begin
                mul_a = {2'b00, mag_reg[step_cnt_reg[1:0]][23:0]};
                mul_b = {2'b00, mag_reg[step_cnt_reg[1:0]][23:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Cell tests
    function automatic logic facing(input logic neg, input logic signed [15:0] z);
        facing = neg ? z[15] : (!z[15] && (z != 16'sd0));
    endfunction

    function automatic logic [16:0] absdiff(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
        logic signed [16:0] d;
        d = 17'(a) - 17'(b);
        absdiff = d[16] ? 17'(-d) : 17'(d);
    endfunction

    logic [17:0] i_tl;
    logic        upper_ok, lower_ok, lastcol, lastrow;
    always_comb
    begin
        i_tl     = base_reg + 18'(col_reg);
        upper_ok = facing(face_neg_reg, cell_reg.tl_z) && facing(face_neg_reg, cell_reg.tr_z)
                && facing(face_neg_reg, cell_reg.bl_z)
                && (23'(absdiff(cell_reg.tl_z, cell_reg.tr_z)) < lim_reg)
                && (23'(absdiff(cell_reg.tl_z, cell_reg.bl_z)) < lim_reg);
        lower_ok = facing(face_neg_reg, cell_reg.br_z) && facing(face_neg_reg, cell_reg.tr_z)
                && facing(face_neg_reg, cell_reg.bl_z)
                && (23'(absdiff(cell_reg.br_z, cell_reg.tr_z)) < lim_reg)
                && (23'(absdiff(cell_reg.br_z, cell_reg.bl_z)) < lim_reg);
        lastcol  = (CMP_W'(col_reg) + (CMP_W'(steps) << 1)) >= CMP_W'(GRID_WIDTH);
        lastrow  = (CMP_W'(row_reg) + (CMP_W'(steps) << 1)) >= CMP_W'(GRID_HEIGHT);
    end

    // Normalize, square-root and divide helpers
    logic        all_zero, mag_big, mag_top;
    logic [49:0] sum_next;
    logic [50:0] bit_val, trial;
    logic [25:0] q_val;
    logic [39:0] dsub;
    logic        hit;
    logic [14:0] quo_new;
    logic [20:0] count_add;
    logic        out_free;
    logic        frame_end;
    logic        result_load;
    state_t      after_norm;
    always_comb
    begin
        all_zero  = (vec_reg[0] == '0) && (vec_reg[1] == '0) && (vec_reg[2] == '0);
        mag_big   = |{mag_reg[0][34:24], mag_reg[1][34:24], mag_reg[2][34:24]};
        mag_top   = mag_reg[0][23] | mag_reg[1][23] | mag_reg[2][23];
        sum_next  = sum_reg + mul_p[49:0];
        bit_val   = 51'(1) << {sq_cnt_reg, 1'b0};
        trial     = root_reg + bit_val;
        q_val     = root_reg[25:0];
        dsub      = 40'(q_val) << div_cnt_reg;
        hit       = num_reg >= dsub;
        quo_new   = quo_reg | (hit ? (15'(1) << div_cnt_reg) : 15'd0);
        count_add = ({1'b0, count_reg} + 22'(dgms_pkg::COUNT_PER_TRI) > 22'(dgms_pkg::COUNT_MAX))
                  ? dgms_pkg::COUNT_MAX : count_reg + dgms_pkg::COUNT_PER_TRI;
        out_free  = !result_valid_reg || !result_stall;
        frame_end = lastcol_reg && lastrow_reg;
        case (phase_reg)
            PH_TL:   after_norm = ST_EMIT_NTL;
            PH_BR:   after_norm = ST_EMIT_NBR;
            default: after_norm = ST_EMIT_BL;
        endcase
        // A new result enters the output register this cycle
        case (state_reg)
            ST_TRI_U, ST_TRI_L, ST_EMIT_NTL, ST_EMIT_NBR, ST_EMIT_BL, ST_EMIT_TR:
                result_load = out_free;
            ST_FIN:
                result_load = out_free && frame_end;
            default:
                result_load = 1'b0;
        endcase
    end

    function automatic dgms_pkg::result_t make_result(
        input logic [1:0]  kind,
        input logic [17:0] ia,
        input logic [17:0] ib,
        input logic [17:0] ic,
        input logic [15:0] nx,
        input logic [15:0] ny,
        input logic [15:0] nz,
        input logic [20:0] cnt,
        input logic        rdy,
        input logic        lst
    );
        dgms_pkg::result_t r;
        r.kind        = kind;
        r.index_a     = ia;
        r.index_b     = ib;
        r.index_c     = ic;
        r.normal_x    = nx;
        r.normal_y    = ny;
        r.normal_z    = nz;
        r.index_count = cnt;
        r.mesh_ready  = rdy;
        r.last        = lst;
        make_result   = r;
    endfunction

    // Sequencer, configuration, position and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_TL;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            step_size_reg    <= dgms_pkg::STEP_SIZE_RESET;
            face_neg_reg     <= dgms_pkg::FACE_NEG_RESET;
            gap_limit_reg    <= dgms_pkg::GAP_LIMIT_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            count_reg        <= '0;
        end
        else
        begin
            // Drop a taken result unless a new one replaces it
            if (result_valid_reg && !result_stall && !result_load)
                result_valid_reg <= 1'b0;

            if (write_enable)
            begin
                case (reg_index)
                    dgms_pkg::REG_STEP_SIZE:       step_size_reg <= write_data[7:0];
                    dgms_pkg::REG_FACE_NEGATIVE_Z: face_neg_reg  <= write_data[0];
                    dgms_pkg::REG_GAP_LIMIT:       gap_limit_reg <= write_data[14:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                    if (cell_valid)
                        state_reg <= ST_LIM;
                ST_LIM:   state_reg <= ST_BASE;
                ST_BASE:  state_reg <= ST_WSTEP;
                ST_WSTEP: state_reg <= ST_TEST;
                ST_TEST:
                begin
                    if (upper_ok)
                        state_reg <= ST_TRI_U;
                    else if (lower_ok)
                        state_reg <= ST_TRI_L;
                    else
                        state_reg <= ST_FIN;
                end
                ST_TRI_U:
                    if (out_free)
                    begin
                        result_reg <= make_result(dgms_pkg::KIND_TRIANGLE, i_tl_reg, i_bl_reg,
                                                  i_tr_reg, '0, '0, '0, '0, 1'b0, 1'b0);
                        result_valid_reg <= 1'b1;
                        count_reg        <= count_add;
                        phase_reg        <= PH_TL;
                        state_reg        <= ST_CROSS;
                    end
                ST_TRI_L:
                    if (out_free)
                    begin
                        result_reg <= make_result(dgms_pkg::KIND_TRIANGLE, i_tr_reg, i_bl_reg,
                                                  i_br_reg, '0, '0, '0, '0, 1'b0, 1'b0);
                        result_valid_reg <= 1'b1;
                        count_reg        <= count_add;
                        phase_reg        <= PH_BR;
                        state_reg        <= ST_CROSS;
                    end
                ST_CROSS:
                    if (step_cnt_reg == 3'd5)
                        state_reg <= ST_NINIT;
                ST_NINIT:
                    state_reg <= all_zero ? after_norm : ST_NORM;
                ST_NORM:
                    if (!mag_big && mag_top)
                        state_reg <= ST_SQ;
                ST_SQ:
                    if (step_cnt_reg == 3'd2)
                        state_reg <= ST_SQRT;
                ST_SQRT:
                    if (sq_cnt_reg == 5'd0)
                        state_reg <= ST_DIVINIT;
                ST_DIVINIT:
                    state_reg <= ST_DIV;
                ST_DIV:
                    if (div_cnt_reg == 4'd0)
                        state_reg <= (comp_reg == 2'd2) ? after_norm : ST_DIVINIT;
                ST_EMIT_NTL:
                    if (out_free)
                    begin
                        result_reg <= make_result(dgms_pkg::KIND_NORMAL, i_tl_reg, '0, '0,
                                                  nres_reg[0], nres_reg[1], nres_reg[2],
                                                  '0, 1'b0, !lower_reg && !frame_end);
                        result_valid_reg <= 1'b1;
                        state_reg        <= lower_reg ? ST_TRI_L : ST_FIN;
                    end
                ST_EMIT_NBR:
                    if (out_free)
                    begin
                        result_reg <= make_result(dgms_pkg::KIND_NORMAL, i_br_reg, '0, '0,
                                                  nres_reg[0], nres_reg[1], nres_reg[2],
                                                  '0, 1'b0, 1'b0);
                        result_valid_reg <= 1'b1;
                        phase_reg        <= PH_AVG;
                        state_reg        <= upper_reg ? ST_NINIT : ST_EMIT_BL;
                    end
                ST_EMIT_BL:
                    if (out_free)
                    begin
                        result_reg <= make_result(dgms_pkg::KIND_NORMAL, i_bl_reg, '0, '0,
                                                  nres_reg[0], nres_reg[1], nres_reg[2],
                                                  '0, 1'b0, 1'b0);
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_EMIT_TR;
                    end
                ST_EMIT_TR:
                    if (out_free)
                    begin
                        result_reg <= make_result(dgms_pkg::KIND_NORMAL, i_tr_reg, '0, '0,
                                                  nres_reg[0], nres_reg[1], nres_reg[2],
                                                  '0, 1'b0, !frame_end);
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_FIN;
                    end
                ST_FIN:
                    if (!frame_end || out_free)
                    begin
                        // Advance the cell position; close the frame on its last cell
                        if (!lastcol_reg)
                            col_reg <= col_reg + COL_W'(steps);
                        else
                        begin
                            col_reg <= '0;
                            if (!lastrow_reg)
                                row_reg <= row_reg + ROW_W'(steps);
                            else
                            begin
                                row_reg    <= '0;
                                result_reg <= make_result(dgms_pkg::KIND_SUMMARY, '0, '0, '0,
                                                          '0, '0, '0, count_reg,
                                                          count_reg >= dgms_pkg::COUNT_READY,
                                                          1'b1);
                                result_valid_reg <= 1'b1;
                                count_reg        <= '0;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (cell_valid)
                    cell_reg <= grid_cell;
            ST_LIM:   lim_reg   <= mul_p[22:0];
            ST_BASE:  base_reg  <= mul_p[17:0];
            ST_WSTEP: wstep_reg <= mul_p[17:0];
            ST_TEST:
            begin
                i_tl_reg    <= i_tl;
                i_tr_reg    <= i_tl + 18'(steps);
                i_bl_reg    <= i_tl + wstep_reg;
                i_br_reg    <= i_tl + wstep_reg + 18'(steps);
                upper_reg   <= upper_ok;
                lower_reg   <= lower_ok;
                lastcol_reg <= lastcol;
                lastrow_reg <= lastrow;
            end
            ST_TRI_U:
            begin
                da_reg[0]    <= 17'(cell_reg.bl_x) - 17'(cell_reg.tl_x);
                da_reg[1]    <= 17'(cell_reg.bl_y) - 17'(cell_reg.tl_y);
                da_reg[2]    <= 17'(cell_reg.bl_z) - 17'(cell_reg.tl_z);
                db_reg[0]    <= 17'(cell_reg.tr_x) - 17'(cell_reg.tl_x);
                db_reg[1]    <= 17'(cell_reg.tr_y) - 17'(cell_reg.tl_y);
                db_reg[2]    <= 17'(cell_reg.tr_z) - 17'(cell_reg.tl_z);
                step_cnt_reg <= '0;
            end
            ST_TRI_L:
            begin
                da_reg[0]    <= 17'(cell_reg.bl_x) - 17'(cell_reg.tr_x);
                da_reg[1]    <= 17'(cell_reg.bl_y) - 17'(cell_reg.tr_y);
                da_reg[2]    <= 17'(cell_reg.bl_z) - 17'(cell_reg.tr_z);
                db_reg[0]    <= 17'(cell_reg.br_x) - 17'(cell_reg.tr_x);
                db_reg[1]    <= 17'(cell_reg.br_y) - 17'(cell_reg.tr_y);
                db_reg[2]    <= 17'(cell_reg.br_z) - 17'(cell_reg.tr_z);
                step_cnt_reg <= '0;
            end
            ST_CROSS:
            begin
                // Two products per cross component, second one subtracted
                if (!step_cnt_reg[0])
                    acc_reg <= mul_p[34:0];
                else
                    vec_reg[step_cnt_reg[2:1]] <= acc_reg - mul_p[34:0];
                step_cnt_reg <= step_cnt_reg + 3'd1;
            end
            ST_NINIT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i]  <= vec_reg[i][34];
                    mag_reg[i]  <= vec_reg[i][34] ? 35'(-vec_reg[i]) : 35'(vec_reg[i]);
                    nres_reg[i] <= '0;
                end
            end
            ST_NORM:
            begin
                // Bring the largest magnitude into [2^23, 2^24)
                if (mag_big)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= mag_reg[i] >> 1;
                end
                else if (!mag_top)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= mag_reg[i] << 1;
                end
                else
                begin
                    sum_reg      <= '0;
                    step_cnt_reg <= '0;
                end
            end
            ST_SQ:
            begin
                sum_reg      <= sum_next;
                step_cnt_reg <= step_cnt_reg + 3'd1;
                s_reg        <= {1'b0, sum_next};
                root_reg     <= '0;
                sq_cnt_reg   <= 5'd24;
            end
            ST_SQRT:
            begin
                if (s_reg >= trial)
                begin
                    s_reg    <= s_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_val;
                end
                else
                    root_reg <= root_reg >> 1;
                sq_cnt_reg <= sq_cnt_reg - 5'd1;
                comp_reg   <= '0;
            end
            ST_DIVINIT:
            begin
                num_reg     <= {2'b00, mag_reg[comp_reg][23:0], 14'd0} + 40'(q_val >> 1);
                quo_reg     <= '0;
                div_cnt_reg <= 4'd14;
            end
            ST_DIV:
            begin
                if (hit)
                    num_reg <= num_reg - dsub;
                quo_reg     <= quo_new;
                div_cnt_reg <= div_cnt_reg - 4'd1;
                if (div_cnt_reg == 4'd0)
                begin
                    nres_reg[comp_reg] <= neg_reg[comp_reg] ? -16'(quo_new) : 16'(quo_new);
                    comp_reg           <= comp_reg + 2'd1;
                end
            end
            ST_EMIT_NTL:
            begin
                for (int i = 0; i < 3; i++)
                    ntl_reg[i] <= nres_reg[i];
            end
            ST_EMIT_NBR:
            begin
                // Sum of both face normals for the shared corners
                for (int i = 0; i < 3; i++)
                    vec_reg[i] <= 35'(ntl_reg[i]) + 35'(nres_reg[i]);
            end
            default: ;
        endcase
    end

    assign cell_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && !cell_stall) |=> (state_reg == ST_LIM))
        else $error("accepted cell did not start the sequence");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.kind == dgms_pkg::KIND_SUMMARY)) |-> result.last)
        else $error("frame summary not marked last");

    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (q_val != 26'd0))
        else $error("divide by zero root");

    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.kind == dgms_pkg::KIND_NORMAL)) |->
        ((result.normal_x <= 16'sd16384) && (result.normal_x >= -16'sd16384)
         && (result.normal_y <= 16'sd16384) && (result.normal_y >= -16'sd16384)
         && (result.normal_z <= 16'sd16384) && (result.normal_z >= -16'sd16384)))
        else $error("normal component out of unit range");

endmodule

`default_nettype wire
